### rtl/core/byte_pattern_remover_unit_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef BYTE_PATTERN_REMOVER_UNIT_DEFINES_SVH
`define BYTE_PATTERN_REMOVER_UNIT_DEFINES_SVH

// Whenever the trigger holds, the consequence must hold in the same cycle.
`define BPR_ASSERT_IMPLY(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("bpr: implication check failed");

// Whenever the trigger holds, the signal keeps its value into the next cycle.
`define BPR_ASSERT_HOLD(label, clk, rst_n, trig, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> $stable(sig)) \
        else $error("bpr: hold check failed");

`endif

### rtl/core/bpr_pkg.sv
package bpr_pkg;

    // Default and upper bound of the pattern length the window supports.
    localparam int PATTERN_MAX_DEF = 8;

    // Field widths fixed by the interface.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 4;
    localparam int BYTE_W     = 8;

    // Counts of bytes in the window or in a burst; covers up to fifteen.
    localparam int CNT_W = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1
    } cfg_reg_e_t;

    // Description of the results one item produces.
    typedef struct packed {
        logic [CNT_W-1:0] count;    // number of results, zero for none
        logic             end_only; // single result that carries no byte
        logic             eos;      // last result closes the string
        logic             none;     // no byte of the string survived
    } burst_ctrl_t;

endpackage

### rtl/core/bpr_window.sv
module bpr_window #(
    parameter int PATTERN_MAX = bpr_pkg::PATTERN_MAX_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         load,
    input  logic [bpr_pkg::BYTE_W-1:0]                   in_byte,
    input  logic                                         is_last,
    input  logic [PATTERN_MAX*bpr_pkg::BYTE_W-1:0]       pattern,
    input  logic [bpr_pkg::LEN_W-1:0]                    len_raw,
    output logic [PATTERN_MAX-1:0][bpr_pkg::BYTE_W-1:0]  burst_bytes,
    output bpr_pkg::burst_ctrl_t                         burst
);
    import bpr_pkg::*;

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(PATTERN_MAX);

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_reg, win_next;
    logic [CNT_W-1:0]                   fill_reg, fill_next;
    logic                               any_reg, any_next;

    logic [CNT_W-1:0]                   eff_len;
    logic [CNT_W-1:0]                   fill_cur;
    logic [CNT_W-1:0]                   n_cnt;
    logic [CNT_W-1:0]                   shrink_cnt;
    logic                               full;
    logic                               match_all;
    logic                               match;
    logic [CNT_W-1:0]                   pop_cnt;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] ext;

    // Effective pattern length: zero acts as one, large values are clamped.
    always_comb
    begin
        priority if (len_raw == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (CNT_W'(len_raw) > MAX_CNT)
        begin
            eff_len = MAX_CNT;
        end
        else
        begin
            eff_len = CNT_W'(len_raw);
        end
    end

    // Append the new byte after the pending bytes.
    always_comb
    begin
        fill_cur = (fill_reg >= MAX_CNT) ? MAX_CNT - CNT_W'(1) : fill_reg;
        n_cnt    = fill_cur + CNT_W'(1);
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            ext[j] = (CNT_W'(j) == fill_cur) ? in_byte : win_reg[j];
        end
    end

    // Oldest bytes beyond the effective length leave before the compare.
    assign shrink_cnt = (n_cnt > eff_len) ? n_cnt - eff_len : '0;
    assign full       = ((n_cnt - shrink_cnt) == eff_len);

    // Compare the remaining window against the pattern, all bytes at once.
    always_comb
    begin
        logic [CNT_W-1:0] cmp_idx;
        match_all = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            cmp_idx = shrink_cnt + CNT_W'(i);
            if (CNT_W'(i) < eff_len)
            begin
                if (ext[cmp_idx[IDX_W-1:0]] != pattern[BYTE_W*i +: BYTE_W])
                begin
                    match_all = 1'b0;
                end
            end
        end
        match = full && match_all;
    end

    // Number of bytes passed on by this item; they are always the oldest ones.
    always_comb
    begin
        priority if (is_last)
        begin
            pop_cnt = match ? shrink_cnt : n_cnt;
        end
        else if (full && !match)
        begin
            pop_cnt = shrink_cnt + CNT_W'(1);
        end
        else
        begin
            pop_cnt = shrink_cnt;
        end
    end

    // Next window contents and string state.
    always_comb
    begin
        logic [CNT_W-1:0] src;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            src = pop_cnt + CNT_W'(j);
            win_next[j] = (src < MAX_CNT) ? ext[src[IDX_W-1:0]] : '0;
        end
        fill_next = (is_last || match) ? '0 : n_cnt - pop_cnt;
        any_next  = is_last ? 1'b0 : (any_reg || (pop_cnt != '0));
    end

    // Results of this item for the output buffer.
    always_comb
    begin
        burst_bytes    = ext;
        burst.end_only = is_last && (pop_cnt == '0);
        burst.count    = (pop_cnt != '0) ? pop_cnt : (is_last ? CNT_W'(1) : '0);
        burst.eos      = is_last;
        burst.none     = is_last && (pop_cnt == '0) && !any_reg;
    end

    // Window state registers, advanced on each accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            fill_reg <= '0;
            any_reg  <= 1'b0;
        end
        else if (load)
        begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
            any_reg  <= any_next;
        end
    end

endmodule

### rtl/core/byte_pattern_remover_unit.sv
// Channel  | Signals                                            | Direction
// ---------+----------------------------------------------------+----------
// in       | in_valid, in_ready, in_byte, is_last               | input
// out      | out_valid, out_ready, out_byte, byte_valid,         | output
//          | end_of_string, nothing_left                        |
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data          | input
//
// One item is accepted per cycle while each item yields at most one result and the
// output is not stalled. An item that yields more than one result (end-of-string
// flush or a shrunk length) holds the input while the burst buffer drains. The
// first result of an item passes from the burst buffer into the output register.
// rst_n clears the control state at once; payloads have no reset. No clearing pass
// is needed. A stalled output fills the output register and then the burst buffer.
module byte_pattern_remover_unit #(
    parameter int PATTERN_MAX = bpr_pkg::PATTERN_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bpr_pkg::BYTE_W-1:0]        in_byte,
    input  logic                              is_last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bpr_pkg::BYTE_W-1:0]        out_byte,
    output logic                              byte_valid,
    output logic                              end_of_string,
    output logic                              nothing_left,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bpr_pkg::*;

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [PATTERN_MAX*BYTE_W-1:0]      pattern_reg;
    logic [LEN_W-1:0]                   length_reg;

    logic                               in_fire;
    logic                               move;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] step_bytes;
    burst_ctrl_t                        step_ctrl;

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] buf_bytes_reg;
    logic [CNT_W-1:0]                   rem_reg;
    logic [CNT_W-1:0]                   pos_reg;
    logic                               buf_end_only_reg;
    logic                               buf_eos_reg;
    logic                               buf_none_reg;

    logic                               out_valid_reg;
    logic [BYTE_W-1:0]                  out_byte_reg;
    logic                               byte_valid_reg;
    logic                               eos_reg;
    logic                               none_reg;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_e_t'(cfg_index))
                REG_PATTERN_BYTES:  pattern_reg <= cfg_data[PATTERN_MAX*BYTE_W-1:0];
                REG_PATTERN_LENGTH: length_reg  <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // The burst buffer moves a result into the output register when it is free.
    assign move     = (rem_reg != '0) && (!out_valid_reg || out_ready);
    assign in_ready = (rem_reg == '0) || ((rem_reg == CNT_W'(1)) && move);
    assign in_fire  = in_valid && in_ready;

    // Window compare and shift for one item.
    bpr_window #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_fire),
        .in_byte     (in_byte),
        .is_last     (is_last),
        .pattern     (pattern_reg),
        .len_raw     (length_reg),
        .burst_bytes (step_bytes),
        .burst       (step_ctrl)
    );

    // Burst buffer control: load on accept, otherwise count down as results leave.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg          <= '0;
            pos_reg          <= '0;
            buf_end_only_reg <= 1'b0;
            buf_eos_reg      <= 1'b0;
            buf_none_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            rem_reg          <= step_ctrl.count;
            pos_reg          <= '0;
            buf_end_only_reg <= step_ctrl.end_only;
            buf_eos_reg      <= step_ctrl.eos;
            buf_none_reg     <= step_ctrl.none;
        end
        else if (move)
        begin
            rem_reg <= rem_reg - CNT_W'(1);
            pos_reg <= pos_reg + CNT_W'(1);
        end
    end

    // Burst payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            buf_bytes_reg <= step_bytes;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_byte_reg   <= buf_end_only_reg ? '0 : buf_bytes_reg[pos_reg[IDX_W-1:0]];
            byte_valid_reg <= !buf_end_only_reg;
            eos_reg        <= buf_eos_reg && (rem_reg == CNT_W'(1));
            none_reg       <= buf_none_reg && (rem_reg == CNT_W'(1));
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign end_of_string = eos_reg;
    assign nothing_left  = none_reg;

endmodule

### rtl/core/bpr_checker.sv
`include "byte_pattern_remover_unit_defines.svh"

module bpr_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [bpr_pkg::BYTE_W-1:0]        out_byte,
    input  logic                              byte_valid,
    input  logic                              end_of_string,
    input  logic                              nothing_left
);

    // A stalled result keeps its byte.
    `BPR_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid && !out_ready, out_byte)

    // An empty result appears only as the end of a string.
    `BPR_ASSERT_IMPLY(a_empty_is_end, clk, rst_n, out_valid && !byte_valid, end_of_string)

    // Nothing left is flagged only on an empty end result.
    `BPR_ASSERT_IMPLY(a_none_empty, clk, rst_n, out_valid && nothing_left, end_of_string && !byte_valid)

    // An empty result carries a zero byte.
    `BPR_ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid && !byte_valid, out_byte == '0)

endmodule

bind byte_pattern_remover_unit bpr_checker u_bpr_checker (.*);
